// ===== rtl/flicker_light_sequencer_defines.svh =====
// Assertion macros used by the checker file.
`ifndef FLICKER_LIGHT_SEQUENCER_DEFINES_SVH
`define FLICKER_LIGHT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset
`define FLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and off during reset
`define FLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fls_pkg.sv =====
package fls_pkg;

    // Field and register widths
    localparam int CFG_W     = 16;
    localparam int CNT_W     = 32;
    localparam int RAND_W    = 32;
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int BIT_CNT_W = $clog2(RAND_W);

    // Default duration multiplier
    localparam int unsigned CYCLE_MULT_DEF = 1;

    // Register indexes
    localparam int CFG_ON_MIN    = 0;
    localparam int CFG_ON_MAX    = 1;
    localparam int CFG_OFF_MIN   = 2;
    localparam int CFG_OFF_MAX   = 3;
    localparam int CFG_PAUSE_MIN = 4;
    localparam int CFG_PAUSE_MAX = 5;
    localparam int CFG_RUN_MIN   = 6;
    localparam int CFG_RUN_MAX   = 7;

    // Request codes
    typedef logic [1:0] req_t;
    localparam req_t REQ_TICK    = 2'd0;
    localparam req_t REQ_ENABLE  = 2'd1;
    localparam req_t REQ_DISABLE = 2'd2;

    // Light modes
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_DISABLED = 2'd0;
    localparam mode_t MODE_ON       = 2'd1;
    localparam mode_t MODE_OFF      = 2'd2;
    localparam mode_t MODE_PAUSED   = 2'd3;

    // Duration ranges that a draw can use
    typedef enum logic [1:0] {
        RANGE_ON,
        RANGE_OFF,
        RANGE_PAUSE,
        RANGE_RUN
    } range_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [RAND_W-1:0] rand_first;
        logic [RAND_W-1:0] rand_second;
    } in_item_t;

    typedef struct packed {
        logic [1:0] light_state;
        logic       state_changed;
    } out_item_t;

    // One duration draw: which range, which random word, which counter
    typedef struct packed {
        range_t rng;
        logic   use_second;
        logic   to_run;
    } draw_job_t;

    typedef struct packed {
        logic      load_item;
        logic      set_mode;
        mode_t     mode;
        logic      dec_phase;
        logic      dec_run;
        logic      mul;
        logic      span;
        logic      div_step;
        logic      load_dest;
        draw_job_t job;
        logic      emit;
        logic      emit_forced;
    } dp_cmd_t;

    typedef struct packed {
        req_t  req_type;
        mode_t mode;
        logic  phase_exp;
        logic  run_exp;
    } dp_status_t;

endpackage

// ===== rtl/fls_ctrl.sv =====
module fls_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  fls_pkg::dp_status_t status,
    output fls_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_MUL,
        S_SPAN,
        S_DIV,
        S_LOAD,
        S_EMIT
    } state_t;

    state_t                         state_reg, state_next;
    logic                           out_valid_reg, out_valid_next;
    logic [fls_pkg::BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    fls_pkg::draw_job_t             job_a_reg, job_a_next;
    fls_pkg::draw_job_t             job_b_reg, job_b_next;
    logic                           two_jobs_reg, two_jobs_next;
    logic                           job_sel_reg, job_sel_next;
    fls_pkg::mode_t                 toggled;
    fls_pkg::range_t                toggle_rng;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Mode and range after a phase expiry while flickering
    assign toggled    = (status.mode == fls_pkg::MODE_ON) ? fls_pkg::MODE_OFF
                                                          : fls_pkg::MODE_ON;
    assign toggle_rng = (status.mode == fls_pkg::MODE_ON) ? fls_pkg::RANGE_OFF
                                                          : fls_pkg::RANGE_ON;

    // Sequence one item and issue datapath commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        bit_cnt_next   = bit_cnt_reg;
        job_a_next     = job_a_reg;
        job_b_next     = job_b_reg;
        two_jobs_next  = two_jobs_reg;
        job_sel_next   = job_sel_reg;
        cmd            = '0;
        cmd.job        = job_sel_reg ? job_b_reg : job_a_reg;

        // Drop the result once its transfer completes
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (status.req_type)
                    fls_pkg::REQ_ENABLE:
                    begin
                        if (status.mode == fls_pkg::MODE_DISABLED)
                        begin
                            cmd.set_mode = 1'b1;
                            cmd.mode     = fls_pkg::MODE_ON;
                        end
                        state_next = S_IDLE;
                    end
                    fls_pkg::REQ_DISABLE:
                    begin
                        cmd.set_mode = 1'b1;
                        cmd.mode     = fls_pkg::MODE_DISABLED;
                        state_next   = S_EMIT;
                    end
                    fls_pkg::REQ_TICK:
                    begin
                        if (status.mode == fls_pkg::MODE_DISABLED)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.dec_phase = 1'b1;
                            cmd.dec_run   = (status.mode != fls_pkg::MODE_PAUSED);
                            state_next    = S_CHECK;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CHECK:
            begin
                job_sel_next = 1'b0;
                if (status.mode == fls_pkg::MODE_PAUSED)
                begin
                    // Pause over: reload run length, then an on duration
                    if (status.phase_exp)
                    begin
                        cmd.set_mode  = 1'b1;
                        cmd.mode      = fls_pkg::MODE_ON;
                        job_a_next    = '{rng: fls_pkg::RANGE_RUN, use_second: 1'b0,
                                          to_run: 1'b1};
                        job_b_next    = '{rng: fls_pkg::RANGE_ON, use_second: 1'b1,
                                          to_run: 1'b0};
                        two_jobs_next = 1'b1;
                        state_next    = S_MUL;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else if (status.run_exp)
                begin
                    // Pause overrides any toggle draw; it takes the second word
                    // when a toggle draw would have come first
                    cmd.set_mode  = 1'b1;
                    cmd.mode      = fls_pkg::MODE_PAUSED;
                    job_a_next    = '{rng: fls_pkg::RANGE_PAUSE, use_second: status.phase_exp,
                                      to_run: 1'b0};
                    two_jobs_next = 1'b0;
                    state_next    = S_MUL;
                end
                else if (status.phase_exp)
                begin
                    cmd.set_mode  = 1'b1;
                    cmd.mode      = toggled;
                    job_a_next    = '{rng: toggle_rng, use_second: 1'b0, to_run: 1'b0};
                    two_jobs_next = 1'b0;
                    state_next    = S_MUL;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                cmd.span     = 1'b1;
                bit_cnt_next = fls_pkg::BIT_CNT_W'(fls_pkg::RAND_W - 1);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            S_LOAD:
            begin
                cmd.load_dest = 1'b1;
                if (two_jobs_reg && !job_sel_reg)
                begin
                    job_sel_next = 1'b1;
                    state_next   = S_MUL;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_forced = (status.req_type == fls_pkg::REQ_DISABLE);
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            job_a_reg     <= '0;
            job_b_reg     <= '0;
            two_jobs_reg  <= 1'b0;
            job_sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            job_a_reg     <= job_a_next;
            job_b_reg     <= job_b_next;
            two_jobs_reg  <= two_jobs_next;
            job_sel_reg   <= job_sel_next;
        end
    end

endmodule

// ===== rtl/fls_datapath.sv =====
module fls_datapath #(
    parameter int unsigned CYCLE_MULT = fls_pkg::CYCLE_MULT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fls_pkg::in_item_t               in_item,
    input  fls_pkg::dp_cmd_t                cmd,
    output fls_pkg::dp_status_t             status,
    input  logic                            cfg_write,
    input  logic [fls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fls_pkg::CFG_W-1:0]       cfg_data,
    output fls_pkg::out_item_t              out_item
);

    localparam int MULT_W = $clog2(CYCLE_MULT + 1);
    localparam int PROD_W = fls_pkg::CFG_W + MULT_W;
    localparam int SEL_W  = $clog2(fls_pkg::CFG_NUM);

    logic [fls_pkg::CFG_W-1:0]   cfg_reg [fls_pkg::CFG_NUM];
    fls_pkg::mode_t              mode_reg;
    fls_pkg::mode_t              before_reg;
    logic [fls_pkg::CNT_W-1:0]   phase_reg;
    logic [fls_pkg::CNT_W-1:0]   run_reg;
    fls_pkg::in_item_t           item_reg;
    logic [PROD_W-1:0]           lo_reg;
    logic [PROD_W-1:0]           hi_reg;
    logic [PROD_W-1:0]           span_reg;
    logic [PROD_W-1:0]           rem_reg, rem_next;
    logic [fls_pkg::RAND_W-1:0]  shift_reg;
    fls_pkg::out_item_t          out_item_reg;

    logic [fls_pkg::CFG_W-1:0]   bound_min;
    logic [fls_pkg::CFG_W-1:0]   bound_max;
    logic [PROD_W:0]             trial;
    logic [PROD_W-1:0]           draw_val;

    // Report latched request, mode and counter expiry
    assign status.req_type  = item_reg.req_type;
    assign status.mode      = mode_reg;
    assign status.phase_exp = (phase_reg == '0) || phase_reg[fls_pkg::CNT_W-1];
    assign status.run_exp   = (run_reg == '0) || run_reg[fls_pkg::CNT_W-1];

    assign out_item = out_item_reg;

    // Select the bounds of the active draw
    always_comb
    begin
        case (cmd.job.rng)
            fls_pkg::RANGE_ON:
            begin
                bound_min = cfg_reg[fls_pkg::CFG_ON_MIN];
                bound_max = cfg_reg[fls_pkg::CFG_ON_MAX];
            end
            fls_pkg::RANGE_OFF:
            begin
                bound_min = cfg_reg[fls_pkg::CFG_OFF_MIN];
                bound_max = cfg_reg[fls_pkg::CFG_OFF_MAX];
            end
            fls_pkg::RANGE_PAUSE:
            begin
                bound_min = cfg_reg[fls_pkg::CFG_PAUSE_MIN];
                bound_max = cfg_reg[fls_pkg::CFG_PAUSE_MAX];
            end
            default:
            begin
                bound_min = cfg_reg[fls_pkg::CFG_RUN_MIN];
                bound_max = cfg_reg[fls_pkg::CFG_RUN_MAX];
            end
        endcase
    end

    // One restoring remainder step: shift in the next random bit
    always_comb
    begin
        trial = {rem_reg, shift_reg[fls_pkg::RAND_W-1]};
        if (trial >= {1'b0, span_reg})
        begin
            rem_next = PROD_W'(trial - {1'b0, span_reg});
        end
        else
        begin
            rem_next = PROD_W'(trial);
        end
    end

    // Duration is the low bound, plus the remainder when the span is nonzero
    assign draw_val = (span_reg == '0) ? lo_reg : (lo_reg + rem_reg);

    // Hold configuration, mode and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fls_pkg::CFG_NUM; i++)
            begin
                cfg_reg[i] <= '0;
            end
            mode_reg  <= fls_pkg::MODE_DISABLED;
            phase_reg <= '0;
            run_reg   <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index < fls_pkg::CFG_IDX_W'(fls_pkg::CFG_NUM)))
            begin
                cfg_reg[cfg_index[SEL_W-1:0]] <= cfg_data;
            end
            if (cmd.set_mode)
            begin
                mode_reg <= cmd.mode;
            end
            if (cmd.dec_phase)
            begin
                phase_reg <= phase_reg - 1'b1;
            end
            if (cmd.dec_run)
            begin
                run_reg <= run_reg - 1'b1;
            end
            if (cmd.load_dest)
            begin
                if (cmd.job.to_run)
                begin
                    run_reg <= fls_pkg::CNT_W'(draw_val);
                end
                else
                begin
                    phase_reg <= fls_pkg::CNT_W'(draw_val);
                end
            end
        end
    end

    // Capture the item, run the draw unit and load the result
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
        if (cmd.dec_phase)
        begin
            before_reg <= mode_reg;
        end
        if (cmd.mul)
        begin
            lo_reg    <= PROD_W'(bound_min) * PROD_W'(CYCLE_MULT);
            hi_reg    <= PROD_W'(bound_max) * PROD_W'(CYCLE_MULT);
            shift_reg <= cmd.job.use_second ? item_reg.rand_second : item_reg.rand_first;
        end
        if (cmd.span)
        begin
            span_reg <= (hi_reg > lo_reg) ? (hi_reg - lo_reg) : '0;
            rem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[fls_pkg::RAND_W-2:0], 1'b0};
        end
        if (cmd.emit)
        begin
            out_item_reg.light_state   <= mode_reg;
            out_item_reg.state_changed <= cmd.emit_forced || (mode_reg != before_reg);
        end
    end

endmodule

// ===== rtl/flicker_light_sequencer.sv =====
// Light-flicker sequencer. Each accepted item is worked on alone, and the
// input stalls until it is done. Each duration draw runs multiply, span, a
// remainder of the 32-bit random word and load; a toggle or pause entry
// draws once and the end of a pause draws twice. The remainder unit works
// one random bit per cycle. Enable gives no result; disable always gives
// one. A finished result waits in an output register, so the next item can be
// accepted while it is stalled. Configuration writes are taken in any cycle
// (ready is always high); indexes above 7 are ignored.
module flicker_light_sequencer #(
    parameter int unsigned CYCLE_MULT = fls_pkg::CYCLE_MULT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  fls_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output fls_pkg::out_item_t              out_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fls_pkg::CFG_W-1:0]       cfg_data
);

    fls_pkg::dp_cmd_t    cmd;
    fls_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    fls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fls_datapath #(
        .CYCLE_MULT (CYCLE_MULT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_item  (out_item)
    );

endmodule

// ===== rtl/fls_checker.sv =====
`include "flicker_light_sequencer_defines.svh"

module fls_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input fls_pkg::out_item_t out_item
);

    // A stalled result holds
    `FLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")

    // An accepted item blocks the input while it is worked on
    `FLS_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "input not stalled after transfer")

    // A disabled result only comes from a disable, which always reports a change
    `FLS_ASSERT_NOW(a_disable_changed, out_valid && (out_item.light_state == fls_pkg::MODE_DISABLED), out_item.state_changed, "disabled result without change flag")

    // A new result only appears at the end of work on an item
    `FLS_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result appeared without an item in work")

endmodule

bind flicker_light_sequencer fls_checker u_fls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
